/* rtl/core/dns_wildcard_a_responder_top_assert.svh */
// Assertion macros shared by the responder RTL.
// Each macro expects signals named clock and reset in the enclosing module.
`ifndef DNS_WILDCARD_A_RESPONDER_TOP_ASSERT_SVH
`define DNS_WILDCARD_A_RESPONDER_TOP_ASSERT_SVH

// The condition holds at every clock edge outside reset.
`define DWAR_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// The consequence holds in the same cycle as the trigger.
`define DWAR_ASSERT_IMPLIES(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// The consequence holds in the cycle after the trigger.
`define DWAR_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

/* rtl/core/dwar_pkg.sv */
// Shared constants, types and byte formatting functions of the DNS responder.
// No dependencies; the RTL modules and the channel interfaces use this package.
package dwar_pkg;

   localparam int MAX_PACKET  = 512;
   localparam int MAX_ANSWERS = 3;
   localparam int HDR_LEN     = 12;
   localparam int HDR_KEEP    = 6;
   localparam int REC_LEN     = 16;
   localparam int Q_DEPTH     = 4;

   localparam int POS_W      = $clog2(MAX_PACKET + 1);
   localparam int ANS_W      = $clog2(MAX_ANSWERS + 1);
   localparam int HOLD_IDX_W = $clog2(HDR_KEEP);
   localparam int BYTE_IDX_W = $clog2(REC_LEN);
   localparam int Q_PTR_W    = $clog2(Q_DEPTH);
   localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);
   localparam int CSR_IDX_W  = 1;

   localparam logic [31:0] IPV4_RESET    = 32'hC0A8_0401;
   localparam logic [31:0] TTL_RESET     = 32'd60;
   localparam logic [7:0]  FLAG_QR_AA    = 8'h84;
   localparam logic [7:0]  RCODE_KEEP    = 8'hF0;
   localparam logic [7:0]  NAME_PTR_HI   = 8'hC0;
   localparam logic [7:0]  NAME_PTR_LO   = 8'h0C;
   localparam logic [7:0]  TYPE_A_LO     = 8'h01;
   localparam logic [7:0]  CLASS_IN_LO   = 8'h01;
   localparam logic [7:0]  RDLEN_LO      = 8'h04;
   localparam logic [15:0] NAME_END_SKIP = 16'd5;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ANSWER_IPV4,
      CSR_ANSWER_TTL
   } csr_index_type;

   typedef enum logic [1:0] {
      CMD_NONE,
      CMD_HEADER,
      CMD_PASS
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type            kind;
      logic [HDR_KEEP*8-1:0]   payload;
      logic                    last_flag;
      logic [ANS_W-1:0]        rec_count;
   } cmd_type;

   typedef struct packed {
      logic    push;
      cmd_type cmd;
   } q_write_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } q_head_type;

   function automatic logic [7:0] hdr_byte(input logic [BYTE_IDX_W-1:0] idx,
                                           input logic [HDR_KEEP*8-1:0] hdr);
      logic [7:0] result;
      case (idx)
         BYTE_IDX_W'(0): result = hdr[47:40];
         BYTE_IDX_W'(1): result = hdr[39:32];
         BYTE_IDX_W'(2): result = hdr[31:24] | FLAG_QR_AA;
         BYTE_IDX_W'(3): result = hdr[23:16] & RCODE_KEEP;
         BYTE_IDX_W'(4), BYTE_IDX_W'(6): result = hdr[15:8];
         BYTE_IDX_W'(5), BYTE_IDX_W'(7): result = hdr[7:0];
         default: result = 8'h00;
      endcase
      return result;
   endfunction

   function automatic logic [7:0] rec_byte(input logic [BYTE_IDX_W-1:0] idx,
                                           input logic [31:0] ttl,
                                           input logic [31:0] ipv4);
      logic [7:0] result;
      case (idx)
         BYTE_IDX_W'(0):  result = NAME_PTR_HI;
         BYTE_IDX_W'(1):  result = NAME_PTR_LO;
         BYTE_IDX_W'(3):  result = TYPE_A_LO;
         BYTE_IDX_W'(5):  result = CLASS_IN_LO;
         BYTE_IDX_W'(6):  result = ttl[31:24];
         BYTE_IDX_W'(7):  result = ttl[23:16];
         BYTE_IDX_W'(8):  result = ttl[15:8];
         BYTE_IDX_W'(9):  result = ttl[7:0];
         BYTE_IDX_W'(11): result = RDLEN_LO;
         BYTE_IDX_W'(12): result = ipv4[31:24];
         BYTE_IDX_W'(13): result = ipv4[23:16];
         BYTE_IDX_W'(14): result = ipv4[15:8];
         BYTE_IDX_W'(15): result = ipv4[7:0];
         default:         result = 8'h00;
      endcase
      return result;
   endfunction

endpackage

/* rtl/core/dwar_channels_if.sv */
// Valid/ready channel interfaces for query bytes, reply bytes and register writes.
// Depends on dwar_pkg for the register index width.
interface dwar_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] packet_byte;
   logic       is_final;
   modport source (output valid, packet_byte, is_final, input ready);
   modport sink (input valid, packet_byte, is_final, output ready);
endinterface

interface dwar_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] reply_byte;
   logic       reply_final;
   modport source (output valid, reply_byte, reply_final, input ready);
   modport sink (input valid, reply_byte, reply_final, output ready);
endinterface

interface dwar_csr_if;
   logic                             valid;
   logic                             ready;
   logic [dwar_pkg::CSR_IDX_W-1:0]   index;
   logic [31:0]                      data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

/* rtl/core/dwar_front.sv */
// Front end: accepts query bytes, holds the header, walks question names and
// queues at most one command per transaction. Depends on dwar_pkg and dwar_req_if.
`include "dns_wildcard_a_responder_top_assert.svh"

module dwar_front (
   input  logic                  clock,
   input  logic                  reset,
   dwar_req_if.sink              req_bus,
   input  logic                  q_full,
   output dwar_pkg::q_write_type q_wr
);
   import dwar_pkg::*;

   logic [7:0]       header_hold_ff [HDR_KEEP];
   logic [POS_W-1:0] byte_position_ff, byte_position_in;
   logic [15:0]      question_total_ff, question_total_in;
   logic [ANS_W-1:0] answers_found_ff, answers_found_in;
   logic [15:0]      questions_started_ff, questions_started_in;
   logic [15:0]      next_mark_ff, next_mark_in;
   logic             inside_name_ff, inside_name_in;

   logic             accept;
   logic             in_range;
   logic [15:0]      pos16;
   logic [7:0]       pkt_byte;
   logic             fin;
   logic [ANS_W-1:0] rec_count;

   assign req_bus.ready = !q_full;
   assign accept        = req_bus.valid && !q_full;
   assign pkt_byte      = req_bus.packet_byte;
   assign fin           = req_bus.is_final;
   assign in_range      = byte_position_ff < POS_W'(MAX_PACKET);
   assign pos16         = 16'(byte_position_ff);

   always_comb begin
      byte_position_in     = in_range ? byte_position_ff + 1'b1 : byte_position_ff;
      question_total_in    = question_total_ff;
      answers_found_in     = answers_found_ff;
      questions_started_in = questions_started_ff;
      next_mark_in         = next_mark_ff;
      inside_name_in       = inside_name_ff;

      if (in_range && byte_position_ff == POS_W'(HDR_LEN - 1)) begin
         question_total_in = {header_hold_ff[4], header_hold_ff[5]};
      end

      if (in_range && byte_position_ff >= POS_W'(HDR_LEN) && pos16 == next_mark_ff &&
          (inside_name_ff || questions_started_ff < question_total_ff)) begin
         if (!inside_name_ff) begin
            questions_started_in = questions_started_ff + 16'd1;
            if (answers_found_ff < ANS_W'(MAX_ANSWERS)) begin
               answers_found_in = answers_found_ff + 1'b1;
            end
         end
         if (pkt_byte == 8'h00) begin
            next_mark_in   = pos16 + NAME_END_SKIP;
            inside_name_in = 1'b0;
         end else begin
            next_mark_in   = pos16 + 16'(pkt_byte) + 16'd1;
            inside_name_in = 1'b1;
         end
      end

      rec_count = (fin && byte_position_in >= POS_W'(HDR_LEN)) ? answers_found_in : '0;

      q_wr.cmd.rec_count = rec_count;
      q_wr.cmd.payload   = {(HDR_KEEP*8){1'b0}};
      q_wr.cmd.last_flag = 1'b0;
      q_wr.cmd.kind      = CMD_NONE;
      if (in_range && byte_position_ff == POS_W'(HDR_LEN - 1)) begin
         q_wr.cmd.kind      = CMD_HEADER;
         q_wr.cmd.payload   = {header_hold_ff[0], header_hold_ff[1], header_hold_ff[2],
                               header_hold_ff[3], header_hold_ff[4], header_hold_ff[5]};
         q_wr.cmd.last_flag = fin;
      end else if (in_range && byte_position_ff >= POS_W'(HDR_LEN)) begin
         q_wr.cmd.kind      = CMD_PASS;
         q_wr.cmd.payload   = (HDR_KEEP*8)'(pkt_byte);
         q_wr.cmd.last_flag = fin && answers_found_in == '0;
      end
      q_wr.push = accept && (q_wr.cmd.kind != CMD_NONE || rec_count != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_position_ff     <= '0;
         question_total_ff    <= '0;
         answers_found_ff     <= '0;
         questions_started_ff <= '0;
         next_mark_ff         <= 16'(HDR_LEN);
         inside_name_ff       <= 1'b0;
      end else if (accept) begin
         if (fin) begin
            byte_position_ff     <= '0;
            question_total_ff    <= '0;
            answers_found_ff     <= '0;
            questions_started_ff <= '0;
            next_mark_ff         <= 16'(HDR_LEN);
            inside_name_ff       <= 1'b0;
         end else begin
            byte_position_ff     <= byte_position_in;
            question_total_ff    <= question_total_in;
            answers_found_ff     <= answers_found_in;
            questions_started_ff <= questions_started_in;
            next_mark_ff         <= next_mark_in;
            inside_name_ff       <= inside_name_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && in_range && byte_position_ff < POS_W'(HDR_KEEP)) begin
         header_hold_ff[byte_position_ff[HOLD_IDX_W-1:0]] <= pkt_byte;
      end
   end

   `DWAR_ASSERT_ALWAYS(a_answers_le_started, 16'(answers_found_ff) <= questions_started_ff, "answer count exceeds started questions")

endmodule

/* rtl/core/dwar_queue.sv */
// Command queue between the front end and the reply generator.
// Depends on dwar_pkg for the command type and depth.
`include "dns_wildcard_a_responder_top_assert.svh"

module dwar_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  dwar_pkg::q_write_type q_wr,
   input  logic                  pop,
   output logic                  full,
   output dwar_pkg::q_head_type  head
);
   import dwar_pkg::*;

   cmd_type            entry_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0] count_ff, count_in;

   assign full       = count_ff == Q_CNT_W'(Q_DEPTH);
   assign head.valid = count_ff != '0;
   assign head.cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (q_wr.push) begin
         wr_ptr_in = (wr_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (q_wr.push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !q_wr.push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_wr.push) begin
         entry_ff[wr_ptr_ff] <= q_wr.cmd;
      end
   end

   `DWAR_ASSERT_IMPLIES(a_no_overflow, q_wr.push, !full, "push into a full command queue")
   `DWAR_ASSERT_NEXT(a_count_grows, q_wr.push && !pop, count_ff == Q_CNT_W'($past(count_ff) + 1'b1), "queue count did not follow a push")

endmodule

/* rtl/core/dwar_back.sv */
// Reply generator: expands queued commands into reply bytes and answer records,
// and holds the answer registers. Depends on dwar_pkg, dwar_rsp_if and dwar_csr_if.
`include "dns_wildcard_a_responder_top_assert.svh"

module dwar_back (
   input  logic                 clock,
   input  logic                 reset,
   input  dwar_pkg::q_head_type head,
   output logic                 pop,
   dwar_rsp_if.source           rsp_bus,
   dwar_csr_if.sink             csr_bus
);
   import dwar_pkg::*;

   typedef enum logic [0:0] {
      ST_PRIMARY,
      ST_RECORDS
   } state_type;

   localparam logic [BYTE_IDX_W-1:0] HDR_LAST = BYTE_IDX_W'(HDR_LEN - 1);
   localparam logic [BYTE_IDX_W-1:0] REC_LAST = BYTE_IDX_W'(REC_LEN - 1);

   state_type             state_ff, state_in;
   logic [BYTE_IDX_W-1:0] idx_ff, idx_in;
   logic [ANS_W-1:0]      rec_ff, rec_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            rsp_byte_ff, rsp_byte_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic [31:0]           answer_ipv4_ff;
   logic [31:0]           answer_ttl_ff;

   logic       can_load;
   logic       step;
   logic       emit;
   logic       seg_end;
   logic       rec_last;
   logic [7:0] out_byte;
   logic       out_last;

   assign can_load = !rsp_valid_ff || rsp_bus.ready;
   assign step     = head.valid && can_load;
   assign rec_last = ANS_W'(rec_ff + 1'b1) == head.cmd.rec_count;

   always_comb begin
      emit     = 1'b0;
      seg_end  = 1'b1;
      out_byte = 8'h00;
      out_last = 1'b0;
      case (state_ff)
         ST_PRIMARY: begin
            case (head.cmd.kind)
               CMD_HEADER: begin
                  emit     = 1'b1;
                  out_byte = hdr_byte(idx_ff, head.cmd.payload);
                  out_last = idx_ff == HDR_LAST && head.cmd.last_flag;
                  seg_end  = idx_ff == HDR_LAST;
               end
               CMD_PASS: begin
                  emit     = 1'b1;
                  out_byte = head.cmd.payload[7:0];
                  out_last = head.cmd.last_flag;
               end
               default: begin
                  emit = 1'b0;
               end
            endcase
         end
         ST_RECORDS: begin
            emit     = 1'b1;
            out_byte = rec_byte(idx_ff, answer_ttl_ff, answer_ipv4_ff);
            out_last = rec_last && idx_ff == REC_LAST;
            seg_end  = idx_ff == REC_LAST;
         end
         default: begin
            emit = 1'b0;
         end
      endcase

      pop = step && seg_end &&
            ((state_ff == ST_RECORDS) ? rec_last : head.cmd.rec_count == '0);

      state_in     = state_ff;
      idx_in       = idx_ff;
      rec_in       = rec_ff;
      rsp_valid_in = can_load ? (step && emit) : rsp_valid_ff;
      rsp_byte_in  = (step && emit) ? out_byte : rsp_byte_ff;
      rsp_last_in  = (step && emit) ? out_last : rsp_last_ff;

      if (step) begin
         if (seg_end) begin
            idx_in = '0;
            if (state_ff == ST_PRIMARY) begin
               if (head.cmd.rec_count != '0) begin
                  state_in = ST_RECORDS;
                  rec_in   = '0;
               end
            end else if (rec_last) begin
               state_in = ST_PRIMARY;
               rec_in   = '0;
            end else begin
               rec_in = rec_ff + 1'b1;
            end
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_PRIMARY;
         idx_ff       <= '0;
         rec_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rec_ff       <= rec_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_byte_ff  <= rsp_byte_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.reply_byte  = rsp_byte_ff;
   assign rsp_bus.reply_final = rsp_last_ff;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         answer_ipv4_ff <= IPV4_RESET;
         answer_ttl_ff  <= TTL_RESET;
      end else if (csr_bus.valid) begin
         case (csr_index_type'(csr_bus.index))
            CSR_ANSWER_IPV4: answer_ipv4_ff <= csr_bus.data;
            CSR_ANSWER_TTL:  answer_ttl_ff  <= csr_bus.data;
            default: begin
            end
         endcase
      end
   end

   `DWAR_ASSERT_IMPLIES(a_records_have_cmd, state_ff == ST_RECORDS, head.valid && head.cmd.rec_count != '0, "record phase without a queued command")

endmodule

/* rtl/core/dns_wildcard_a_responder_top.sv */
// Top level of the wildcard A-record DNS responder.
// Depends on dwar_pkg, the channel interfaces, dwar_front, dwar_queue and dwar_back.

// The block takes a DNS query one byte per transaction on req_bus and returns
// the reply on rsp_bus, one byte per transaction, at up to one byte per cycle on
// each side. The first eleven query bytes give no output; the twelfth releases the
// twelve reply header bytes, every later byte up to the 512th passes through as one
// reply byte, and the final byte is followed by 16 record bytes per answer, at most
// 48. A four-entry command queue sits between the query parser and the reply
// generator, so the parser keeps taking bytes while the generator streams a header
// or records; req_bus stalls only while that queue is full. The user must write the
// answer address and TTL through csr_bus (index 0 and 1) only while no packet is in
// flight; the block itself does not enforce it.
module dns_wildcard_a_responder_top (
   input  logic       clock,
   input  logic       reset,
   dwar_req_if.sink   req_bus,
   dwar_rsp_if.source rsp_bus,
   dwar_csr_if.sink   csr_bus
);
   import dwar_pkg::*;

   q_write_type q_wr;
   q_head_type  q_head;
   logic        q_full;
   logic        q_pop;

   dwar_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .q_full  (q_full),
      .q_wr    (q_wr)
   );

   dwar_queue u_queue (
      .clock (clock),
      .reset (reset),
      .q_wr  (q_wr),
      .pop   (q_pop),
      .full  (q_full),
      .head  (q_head)
   );

   dwar_back u_back (
      .clock   (clock),
      .reset   (reset),
      .head    (q_head),
      .pop     (q_pop),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

endmodule
